// ===== hdl/uvs_pkg.sv =====
package uvs_pkg;

  // register indexes
  localparam logic [1:0] REG_STACK  = 2'd0;
  localparam logic [1:0] REG_SECTOR = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_TRI    = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  // largest usable stack and sector count
  localparam int MAX_SEGMENTS = 1024;

  // divider and cordic geometry
  localparam int DIV_STEPS    = 32;
  localparam int DIV_LAT      = DIV_STEPS + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int COR_LAT      = CORDIC_STEPS + 2;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032874;

  // per-point index data that rides along the pipeline
  typedef struct packed {
    logic [20:0] k1;
    logic [10:0] se;
    logic [4:0]  mask;
  } sb_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [12:0] div_step(input logic [11:0] r, input logic [11:0] d);
    logic [12:0] two_r;
    logic        ge;
    logic [12:0] diff;
    two_r = {r, 1'b0};
    ge    = two_r >= {1'b0, d};
    diff  = two_r - {1'b0, d};
    return ge ? {1'b1, diff[11:0]} : {1'b0, two_r[11:0]};
  endfunction

  // arctangent of 2^-n in binary turns scaled by 2^32
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] n);
    case (n)
      5'd0:  return 34'sd536870912;
      5'd1:  return 34'sd316933406;
      5'd2:  return 34'sd167458907;
      5'd3:  return 34'sd85004756;
      5'd4:  return 34'sd42667331;
      5'd5:  return 34'sd21354465;
      5'd6:  return 34'sd10679838;
      5'd7:  return 34'sd5340245;
      5'd8:  return 34'sd2670163;
      5'd9:  return 34'sd1335087;
      5'd10: return 34'sd667544;
      5'd11: return 34'sd333772;
      5'd12: return 34'sd166886;
      5'd13: return 34'sd83443;
      5'd14: return 34'sd41722;
      5'd15: return 34'sd20861;
      5'd16: return 34'sd10430;
      5'd17: return 34'sd5215;
      5'd18: return 34'sd2608;
      5'd19: return 34'sd1304;
      5'd20: return 34'sd652;
      5'd21: return 34'sd326;
      5'd22: return 34'sd163;
      5'd23: return 34'sd81;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== hdl/uvs_div.sv =====
module uvs_div import uvs_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [10:0] num,
  input  logic [11:0] den,
  input  logic [11:0] half,
  output logic [31:0] quot
);

  logic [11:0] rem [0:DIV_STEPS-1];
  logic [31:0] q   [0:DIV_STEPS-1];
  logic [11:0] d   [0:DIV_STEPS-1];
  logic [11:0] h   [0:DIV_STEPS-1];
  logic [12:0] nxt [1:DIV_STEPS-1];
  logic [11:0] init_r;
  logic [12:0] first;
  logic [12:0] rsum;

  // drop the integer part (only when num is at least den), then the first step
  assign init_r = ({1'b0, num} >= den) ? 12'({1'b0, num} - den) : {1'b0, num};
  assign first  = div_step(init_r, den);
  assign rsum   = {1'b0, rem[DIV_STEPS-1]} + {1'b0, h[DIV_STEPS-1]};

  // step result of every later stage
  always_comb begin
    for (int k = 1; k < DIV_STEPS; k++) nxt[k] = div_step(rem[k-1], d[k-1]);
  end

  // one quotient bit per stage, round half up at the end
  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= first[11:0];
      q[0]   <= {31'd0, first[12]};
      d[0]   <= den;
      h[0]   <= half;
      for (int k = 1; k < DIV_STEPS; k++) begin
        rem[k] <= nxt[k][11:0];
        q[k]   <= {q[k-1][30:0], nxt[k][12]};
        d[k]   <= d[k-1];
        h[k]   <= h[k-1];
      end
      quot <= q[DIV_STEPS-1] + {31'd0, (rsum >= {1'b0, d[DIV_STEPS-1]})};
    end
  end

endmodule

// ===== hdl/uvs_cordic.sv =====
module uvs_cordic import uvs_pkg::*; (
  input  logic               clk,
  input  logic               adv,
  input  logic [31:0]        phase,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  logic [1:0]           quad [0:CORDIC_STEPS];
  logic signed [CW-1:0] x    [0:CORDIC_STEPS];
  logic signed [CW-1:0] y    [0:CORDIC_STEPS];
  logic signed [CW-1:0] z    [0:CORDIC_STEPS];
  logic [31:0]          sum;
  logic [1:0]           qc;
  logic [31:0]          dres;
  logic signed [CW-1:0] neg_x;
  logic signed [CW-1:0] neg_y;

  // quadrant reduction to a residual in [-45, 45) degrees
  assign sum   = phase + 32'h2000_0000;
  assign qc    = sum[31:30];
  assign dres  = phase - {qc, 30'd0};
  assign neg_x = -x[CORDIC_STEPS];
  assign neg_y = -y[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      x[0]    <= CORDIC_GAIN_INV;
      y[0]    <= '0;
      z[0]    <= {{(CW-32){dres[31]}}, dres};
      quad[0] <= qc;
      // one rotation per stage
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (z[k][CW-1]) begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + atan_turn(5'(k));
        end else begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - atan_turn(5'(k));
        end
        quad[k+1] <= quad[k];
      end
      // map back to the full circle
      case (quad[CORDIC_STEPS])
        2'd0: begin
          cos_out <= x[CORDIC_STEPS][31:0];
          sin_out <= y[CORDIC_STEPS][31:0];
        end
        2'd1: begin
          cos_out <= neg_y[31:0];
          sin_out <= x[CORDIC_STEPS][31:0];
        end
        2'd2: begin
          cos_out <= neg_x[31:0];
          sin_out <= neg_y[31:0];
        end
        default: begin
          cos_out <= y[CORDIC_STEPS][31:0];
          sin_out <= neg_x[31:0];
        end
      endcase
    end
  end

endmodule

// ===== hdl/uv_sphere_mesh_generator_unit.sv =====
// a request passes the input register, dividers, cordics, product and rounding registers and output register
// throughput: one request per cycle while the output is ready and each point yields a single result;
// a cell point yields 3 to 5 results, one per accepted transfer, and holds the pipeline until the last
// the whole pipeline moves on one enable set by the output stage
// reset: synchronous, counts return to 16 stacks and 32 sectors, pipeline empties
module uv_sphere_mesh_generator_unit import uvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [10:0]        stack_index,
  input  logic [10:0]        sector_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic signed [15:0] coord_x,
  output logic signed [15:0] coord_y,
  output logic signed [15:0] coord_z,
  output logic [20:0]        index_a,
  output logic [20:0]        index_b,
  output logic [20:0]        index_c,
  output logic               last
);

  localparam int PL = DIV_LAT + COR_LAT + 2;

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  logic [10:0] stack_count;
  logic [10:0] sector_count;
  logic        r0v;
  logic [10:0] r0_i;
  logic [10:0] r0_j;
  logic        adv;
  logic [10:0] st;
  logic [10:0] se;
  logic [10:0] ci;
  logic [10:0] cj;
  logic [23:0] k1_full;
  logic        cell_pt;
  sb_t         sb_in;
  logic        vpipe [0:PL-1];
  sb_t         sb    [0:PL-1];
  logic [31:0] qu;
  logic [31:0] qv;
  logic [31:0] pu;
  logic signed [31:0] cu;
  logic signed [31:0] su;
  logic signed [31:0] cv;
  logic signed [31:0] sv;
  logic signed [63:0] pxx;
  logic signed [63:0] pxy;
  logic signed [31:0] psz;
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic signed [15:0] rz;
  logic signed [63:0] tx;
  logic signed [63:0] ty;
  logic signed [63:0] tz;
  logic        ev;
  logic [4:0]  mask;
  logic [4:0]  mask_next;
  logic [4:0]  low;
  logic [20:0] ek1;
  logic [10:0] ese;
  logic signed [15:0] ex;
  logic signed [15:0] ey;
  logic signed [15:0] ez;
  logic [20:0] k1p1;
  logic [20:0] k2;
  logic [20:0] k2p1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count  <= 11'd16;
      sector_count <= 11'd32;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STACK:  stack_count  <= cfg_data;
        REG_SECTOR: sector_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // used counts and clamped indices
  always_comb begin
    if (stack_count < 11'd2) st = 11'd2;
    else if ({2'b0, stack_count} > 13'(MAX_SEGMENTS)) st = 11'(MAX_SEGMENTS);
    else st = stack_count;
    if (sector_count < 11'd3) se = 11'd3;
    else if ({2'b0, sector_count} > 13'(MAX_SEGMENTS)) se = 11'(MAX_SEGMENTS);
    else se = sector_count;
    ci      = (r0_i > st) ? st : r0_i;
    cj      = (r0_j > se) ? se : r0_j;
    cell_pt = (ci < st) && (cj < se);
    k1_full = {1'b0, ci} * ({1'b0, se} + 12'd1) + {13'd0, cj};
    sb_in.k1   = k1_full[20:0];
    sb_in.se   = se;
    sb_in.mask = {cell_pt && (ci != 11'd0), cell_pt, cell_pt && (ci != st - 11'd1),
                  cell_pt && (ci != 11'd0), 1'b1};
  end

  // input register
  assign in_ready = adv;
  always_ff @(posedge clk) begin
    if (rst) begin
      r0v <= 1'b0;
    end else if (adv) begin
      r0v <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      r0_i <= stack_index;
      r0_j <= sector_index;
    end
  end

  // phase division: stack uses twice the count to get half-turn scaling
  uvs_div u_div_stack (
    .clk(clk), .adv(adv), .num(ci),
    .den({st, 1'b0}), .half({1'b0, st[10:1], 1'b0}), .quot(qu)
  );
  uvs_div u_div_sector (
    .clk(clk), .adv(adv), .num(cj),
    .den({1'b0, se}), .half({2'b0, se[10:1]}), .quot(qv)
  );

  assign pu = 32'h4000_0000 - qu;

  uvs_cordic u_cordic_stack (
    .clk(clk), .adv(adv), .phase(pu), .cos_out(cu), .sin_out(su)
  );
  uvs_cordic u_cordic_sector (
    .clk(clk), .adv(adv), .phase(qv), .cos_out(cv), .sin_out(sv)
  );

  // products, then rounding with saturation
  assign tx = (pxx + (64'sd1 <<< 44)) >>> 45;
  assign ty = (pxy + (64'sd1 <<< 44)) >>> 45;
  assign tz = (64'(psz) + 64'sd16384) >>> 15;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxx <= cu * cv;
      pxy <= cu * sv;
      psz <= su;
      rx  <= sat16(tx);
      ry  <= sat16(ty);
      rz  <= sat16(tz);
    end
  end

  // valid bits and index data ride alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PL; k++) vpipe[k] <= 1'b0;
    end else if (adv) begin
      vpipe[0] <= r0v;
      for (int k = 1; k < PL; k++) vpipe[k] <= vpipe[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= sb_in;
      for (int k = 1; k < PL; k++) sb[k] <= sb[k-1];
    end
  end

  // output stage walks the pending results of one point
  assign low       = mask & (~mask + 5'd1);
  assign mask_next = mask & ~low;
  assign last      = (mask_next == 5'd0);
  assign out_valid = ev;
  assign adv       = !ev || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev   <= 1'b0;
      mask <= '0;
    end else if (adv) begin
      ev   <= vpipe[PL-1];
      mask <= vpipe[PL-1] ? sb[PL-1].mask : 5'd0;
    end else if (out_ready) begin
      mask <= mask_next;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ek1 <= sb[PL-1].k1;
      ese <= sb[PL-1].se;
      ex  <= rx;
      ey  <= ry;
      ez  <= rz;
    end
  end

  assign k1p1 = ek1 + 21'd1;
  assign k2   = ek1 + {10'd0, ese} + 21'd1;
  assign k2p1 = k2 + 21'd1;

  // result fields for the current pending kind
  always_comb begin
    kind    = KIND_VERTEX;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    index_a = '0;
    index_b = '0;
    index_c = '0;
    case (low)
      5'b00001: begin
        coord_x = ex;
        coord_y = ey;
        coord_z = ez;
      end
      5'b00010: begin
        kind = KIND_TRI; index_a = ek1; index_b = k1p1; index_c = k2;
      end
      5'b00100: begin
        kind = KIND_TRI; index_a = k1p1; index_b = k2p1; index_c = k2;
      end
      5'b01000: begin
        kind = KIND_LINE; index_a = ek1; index_b = k2;
      end
      5'b10000: begin
        kind = KIND_LINE; index_a = ek1; index_b = k1p1;
      end
      default: ;
    endcase
  end

  // a held point always has something left to send
  assert property (@(posedge clk) disable iff (rst) ev |-> mask != 5'd0)
    else $error("output stage valid with no pending result");

  // every point starts with its vertex
  assert property (@(posedge clk) disable iff (rst)
    adv && vpipe[PL-1] |=> out_valid && kind == KIND_VERTEX)
    else $error("point did not start with a vertex");

  // a stall freezes the pipeline tail
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vpipe[PL-1]) && $stable(ek1))
    else $error("pipeline moved during a stall");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import uvs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;
  localparam longint unsigned MAX_SEG = 1024;

  // one result as seen on the output port
  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [20:0]        a;
    logic [20:0]        b;
    logic [20:0]        c;
    logic               last;
  } mesh_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = REG_STACK;
  logic [10:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [10:0]        stack_index = '0;
  logic [10:0]        sector_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic signed [15:0] coord_x;
  logic signed [15:0] coord_y;
  logic signed [15:0] coord_z;
  logic [20:0]        index_a;
  logic [20:0]        index_b;
  logic [20:0]        index_c;
  logic               last;

  // predictor state: register copies and pending results
  logic [10:0] model_stacks = 11'd16;
  logic [10:0] model_sectors = 11'd32;
  mesh_item_t  pending_mesh[$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          send_gaps = 1'b0;
  bit          recv_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  uv_sphere_mesh_generator_unit dut (.*);

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // arctangent table in binary turns
  function automatic longint atan_step(int n);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                        21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                        333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                        1304, 652, 326, 163, 81};
    return tbl[n];
  endfunction

  // cordic cosine/sine of a phase, scaled by 2^30
  task automatic phase_sincos(input logic [31:0] p, output longint c, output longint s);
    logic [31:0] q;
    logic [31:0] d;
    longint      z;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    q = ((p + 32'h2000_0000) >> 30) & 32'd3;
    d = p - (q << 30);
    z = longint'(signed'(d));
    x = 64'sd652032874;
    y = 0;
    for (int n = 0; n < 24; n++) begin
      dx = y >>> n;
      dy = x >>> n;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_step(n);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_step(n);
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [15:0] round_q15(longint v, int k);
    longint t;
    t = (v + (64'sd1 <<< (k - 1))) >>> k;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return t[15:0];
  endfunction

  function automatic longint unsigned clamp_count(longint unsigned v, longint unsigned lo);
    if (v < lo) return lo;
    if (v > MAX_SEG) return MAX_SEG;
    return v;
  endfunction

  function automatic mesh_item_t idx_item(logic [1:0] k, longint unsigned a,
                                          longint unsigned b, longint unsigned c);
    mesh_item_t r;
    r = '{kind: k, x: 0, y: 0, z: 0, a: a[20:0], b: b[20:0], c: c[20:0], last: 0};
    return r;
  endfunction

  // expected vertex and cell primitives of one grid point
  task automatic predict_point(input logic [10:0] si, input logic [10:0] sj);
    longint unsigned st, se, i, j, k1, k2;
    logic [31:0]     pv, pu;
    longint          cu, su, cv, sv;
    mesh_item_t      res[$];
    mesh_item_t      v;
    st = clamp_count(model_stacks, 2);
    se = clamp_count(model_sectors, 3);
    i = (si > st) ? st : si;
    j = (sj > se) ? se : sj;
    pv = 32'(((j << 32) + se / 2) / se);
    pu = 32'h4000_0000 - 32'(((i << 31) + st / 2) / st);
    phase_sincos(pu, cu, su);
    phase_sincos(pv, cv, sv);
    v = '{kind: KIND_VERTEX, x: round_q15(cu * cv, 45), y: round_q15(cu * sv, 45),
          z: round_q15(su, 15), a: 0, b: 0, c: 0, last: 0};
    res = {res, v};
    if (i < st && j < se) begin
      k1 = i * (se + 1) + j;
      k2 = k1 + se + 1;
      if (i != 0) res = {res, idx_item(KIND_TRI, k1, k1 + 1, k2)};
      if (i != st - 1) res = {res, idx_item(KIND_TRI, k1 + 1, k2 + 1, k2)};
      res = {res, idx_item(KIND_LINE, k1, k2, 0)};
      if (i != 0) res = {res, idx_item(KIND_LINE, k1, k1 + 1, 0)};
    end
    res[res.size() - 1].last = 1'b1;
    pending_mesh = {pending_mesh, res};
  endtask

  // send one grid point request
  task automatic send_point(input logic [10:0] si, input logic [10:0] sj);
    int gap;
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    stack_index = si;
    sector_index = sj;
    do @(posedge clk); while (!in_ready);
    predict_point(si, sj);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (pending_mesh.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_STACK) model_stacks = val;
    else if (idx == REG_SECTOR) model_sectors = val;
  endtask

  task automatic set_counts(input logic [10:0] st, input logic [10:0] se);
    wait_drained();
    write_reg(REG_STACK, st);
    write_reg(REG_SECTOR, se);
  endtask

  function automatic logic [10:0] pick_index(longint unsigned cnt);
    if ($urandom_range(0, 9) == 0) return 11'($urandom_range(0, 2047));
    return 11'($urandom_range(0, int'(cnt)));
  endfunction

  task automatic random_points(input int n);
    for (int k = 0; k < n; k++)
      send_point(pick_index(clamp_count(model_stacks, 2)),
                 pick_index(clamp_count(model_sectors, 3)));
  endtask

  // receiver ready with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    mesh_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_mesh.size() == 0) begin
        $error("unexpected result kind=%0d", kind);
        err_count++;
      end else begin
        e = pending_mesh.pop_front();
        if (kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, kind); err_count++;
        end
        if (coord_x !== e.x) begin
          $error("coord_x exp %0d got %0d", e.x, coord_x); err_count++;
        end
        if (coord_y !== e.y) begin
          $error("coord_y exp %0d got %0d", e.y, coord_y); err_count++;
        end
        if (coord_z !== e.z) begin
          $error("coord_z exp %0d got %0d", e.z, coord_z); err_count++;
        end
        if (index_a !== e.a) begin
          $error("index_a exp %0d got %0d", e.a, index_a); err_count++;
        end
        if (index_b !== e.b) begin
          $error("index_b exp %0d got %0d", e.b, index_b); err_count++;
        end
        if (index_c !== e.c) begin
          $error("index_c exp %0d got %0d", e.c, index_c); err_count++;
        end
        if (last !== e.last) begin
          $error("last exp %0d got %0d", e.last, last); err_count++;
        end
      end
    end
  end

  // poles, seam, last row, clamped indices under reset counts
  task automatic test_reset_counts();
    send_point(0, 0);
    send_point(1, 0);
    send_point(8, 8);
    send_point(15, 31);
    send_point(16, 32);
    send_point(16, 0);
    send_point(0, 32);
    send_point(11'd2047, 11'd2047);
    send_point(4, 24);
    send_point(12, 16);
  endtask

  // smallest and largest grids, plus out-of-range counts
  task automatic test_extreme_counts();
    set_counts(2, 3);
    send_point(0, 0); send_point(1, 2); send_point(2, 3); send_point(1, 1);
    set_counts(1024, 1024);
    send_point(0, 1023); send_point(1023, 1023); send_point(512, 256);
    send_point(1024, 1024); send_point(1023, 0);
    set_counts(0, 0);
    send_point(0, 0); send_point(1, 2); send_point(2, 1);
    set_counts(11'd2047, 11'd2047);
    send_point(1023, 1023); send_point(11'd1365, 11'd682);
  endtask

  task automatic test_random_grids();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    for (int p = 0; p < 4; p++) begin
      set_counts(11'($urandom_range(2, 40)), 11'($urandom_range(3, 40)));
      random_points(12);
    end
    set_counts(11'($urandom_range(2, 1024)), 11'($urandom_range(3, 1024)));
    random_points(12);
  endtask

  // receiver holds off long while requests keep coming, then sender pauses
  task automatic test_backpressure();
    set_counts(11'($urandom_range(3, 30)), 11'($urandom_range(3, 30)));
    @(negedge clk);
    hold_req = 1'b1;
    random_points(40);
    wait_drained();
    random_points(6);
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    set_counts(11'($urandom_range(2, 64)), 11'($urandom_range(3, 64)));
    random_points(20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_counts();
    test_extreme_counts();
    test_random_grids();
    test_backpressure();
    test_full_rate();
    wait_drained();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
